### design/rmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_pkg: shared definitions for the running median tracker
// Sizes, the value type and the control bundle that drives each sorted chain.
// ----------------------------------------------------------------------------
package rmt_pkg;

    // Store size and field widths.
    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_WIDTH = 11;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Each half of the store holds at most this many values.
    localparam int HALF_CAP = (CAPACITY + 1) / 2;
    localparam int HALF_W   = $clog2(HALF_CAP + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [HALF_W-1:0]             t_half_count;

    // Operations applied to every cell of a chain together.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_PUSH,
        OP_REPLACE
    } t_chain_op;

    // Control broadcast to every cell of one chain.
    typedef struct packed {
        t_chain_op   op;
        t_value      key;
        t_half_count count;
    } t_chain_ctrl;

endpackage

### design/rmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_cell: one slot of an ascending sorted chain
// Holds one value, compares it with the broadcast key and takes its next
// value from itself, the key or one of its two neighbors.
// ----------------------------------------------------------------------------
module rmt_cell
    import rmt_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  t_half_count i_index,
    input  t_value      i_left_value,
    input  logic        i_left_gt,
    input  t_value      i_right_value,
    input  logic        i_right_gt,
    output t_value      o_value,
    output logic        o_gt
);

    t_value r_value;
    t_value n_value;
    logic   first;

    // A slot past the fill level counts as greater than any key.
    assign o_gt    = (i_index >= i_ctrl.count) || (r_value > i_ctrl.key);
    assign o_value = r_value;
    assign first   = (i_index == '0);

    // Next value for each chain operation.
    always_comb begin
        unique case (i_ctrl.op)
            OP_HOLD: begin
                n_value = r_value;
            end
            OP_INSERT: begin
                // Slots above the insertion point shift up by one.
                if (o_gt) begin
                    n_value = i_left_gt ? i_left_value : i_ctrl.key;
                end else begin
                    n_value = r_value;
                end
            end
            OP_PUSH: begin
                n_value = i_left_value;
            end
            OP_REPLACE: begin
                // The head leaves; slots below the key shift down by one.
                if (!i_right_gt) begin
                    n_value = i_right_value;
                end else if (!o_gt || first) begin
                    n_value = i_ctrl.key;
                end else begin
                    n_value = r_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### design/rmt_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_chain: ascending sorted chain of cells
// A row of cells that together insert, push at the head or replace the head.
// The head cell holds the smallest stored value.
// ----------------------------------------------------------------------------
module rmt_chain
    import rmt_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    output t_value      o_head
);

    t_value values [HALF_CAP];
    logic   gts    [HALF_CAP];

    // Row of cells, each wired to its two neighbors.
    for (genvar g = 0; g < HALF_CAP; g++) begin : g_cell
        t_value left_value;
        logic   left_gt;
        t_value right_value;
        logic   right_gt;

        if (g == 0) begin : g_first
            assign left_value = i_ctrl.key;
            assign left_gt    = 1'b0;
        end else begin : g_inner_left
            assign left_value = values[g-1];
            assign left_gt    = gts[g-1];
        end

        if (g == HALF_CAP - 1) begin : g_last
            assign right_value = i_ctrl.key;
            assign right_gt    = 1'b1;
        end else begin : g_inner_right
            assign right_value = values[g+1];
            assign right_gt    = gts[g+1];
        end

        rmt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (i_ctrl),
            .i_index       (HALF_W'(g)),
            .i_left_value  (left_value),
            .i_left_gt     (left_gt),
            .i_right_value (right_value),
            .i_right_gt    (right_gt),
            .o_value       (values[g]),
            .o_gt          (gts[g])
        );
    end

    assign o_head = values[0];

endmodule

### design/running_median_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_tracker_top: running lower median of a sample stream
// Keeps accepted samples, up to the capacity, in two sorted cell chains and
// reports the lower median, the stored count and a drop flag per sample.
//
//   Channel  | Handshake                        | Payload
//   ---------+----------------------------------+--------------------------
//   sample   | i_sample_valid / o_sample_ready  | i_sample
//   result   | o_result_valid / i_result_ready  | o_median, o_stored_count,
//            |                                  | o_dropped
//
// A sample is inserted in the cycle of its transfer and its result appears
// on the next cycle, so one sample is taken per cycle while results are
// drained. Each insert ends in the cycle of the transfer, setting that
// rate. Reset clears the fill count and the result register only; the
// cells need no clearing pass. A stalled result holds the sample input off.
// ----------------------------------------------------------------------------
module running_median_tracker_top
    import rmt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sample_valid,
    output logic                   o_sample_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_sample,
    output logic                   o_result_valid,
    input  logic                   i_result_ready,
    output logic signed [VALUE_WIDTH-1:0] o_median,
    output logic [COUNT_WIDTH-1:0] o_stored_count,
    output logic                   o_dropped
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_dropped;
    logic             n_dropped;

    logic        accept;
    logic        full;
    t_half_count low_count;
    t_half_count up_count;
    t_value      low_head;
    t_value      up_head;
    t_value      median;
    t_chain_ctrl low_ctrl;
    t_chain_ctrl up_ctrl;

    // The lower half is stored bit-inverted so both chains sort ascending;
    // its head is then the largest value of the lower half, the median.
    assign median    = ~low_head;
    assign up_count  = HALF_W'(r_count >> 1);
    assign low_count = HALF_W'(r_count - (r_count >> 1));
    assign full      = (r_count == CNT_W'(CAPACITY));

    assign o_sample_ready = !r_out_valid || i_result_ready;
    assign accept         = i_sample_valid && o_sample_ready;

    // Choose the chain operations that keep the halves balanced.
    always_comb begin
        low_ctrl.op    = OP_HOLD;
        low_ctrl.key   = ~i_sample;
        low_ctrl.count = low_count;
        up_ctrl.op     = OP_HOLD;
        up_ctrl.key    = i_sample;
        up_ctrl.count  = up_count;
        if (accept && !full) begin
            if (!r_count[0]) begin
                // Even count: the lower half grows by one.
                if (up_count == '0 || i_sample <= up_head) begin
                    low_ctrl.op = OP_INSERT;
                end else begin
                    low_ctrl.op  = OP_PUSH;
                    low_ctrl.key = ~up_head;
                    up_ctrl.op   = OP_REPLACE;
                end
            end else begin
                // Odd count: the upper half grows by one.
                if (i_sample >= median) begin
                    up_ctrl.op = OP_INSERT;
                end else begin
                    up_ctrl.op   = OP_PUSH;
                    up_ctrl.key  = median;
                    low_ctrl.op  = OP_REPLACE;
                end
            end
        end
    end

    rmt_chain u_low_chain (
        .i_clk  (i_clk),
        .i_ctrl (low_ctrl),
        .o_head (low_head)
    );

    rmt_chain u_up_chain (
        .i_clk  (i_clk),
        .i_ctrl (up_ctrl),
        .o_head (up_head)
    );

    // Fill count, drop flag and result valid.
    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && !i_result_ready;
        if (accept) begin
            n_out_valid = 1'b1;
            n_dropped   = full;
            if (!full) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dropped   <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_dropped   <= n_dropped;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_median       = median;
    assign o_stored_count = COUNT_WIDTH'(r_count);
    assign o_dropped      = r_dropped;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A dropped sample is only reported against a full store.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_dropped |-> full)
        else $error("drop reported with room in the store");

    // An inserted sample raises the count by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !full |=> r_count == $past(r_count) + 1'b1)
        else $error("fill count did not advance on insertion");

    // The lower half never holds a value above the upper half's smallest.
    a_halves_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && r_count >= CNT_W'(2) |-> median <= up_head)
        else $error("median above the upper half");

endmodule
